[rtl/cae_pkg.sv]
// shared types, constants and helper functions for the complementary attitude estimator
package cae_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] REG_ATT_WEIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_WEIGHT = 1'b1;
  localparam logic [16:0] ATT_WEIGHT_RST = 17'd64225;
  localparam logic [16:0] ALT_WEIGHT_RST = 17'd6554;
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;
  localparam int ATAN_DEPTH = 32;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GYRO,
    ST_SQRT_R,
    ST_CORDIC_R,
    ST_SQRT_P,
    ST_CORDIC_P,
    ST_BLEND,
    ST_ALT,
    ST_DIV,
    ST_DONE
  } cae_state_t;

  // arctangent table, radians Q24
  function automatic logic [23:0] atan_q24(input logic [4:0] idx);
    logic [23:0] v;
    begin
      unique case (idx)
        5'd0: v = 24'd13176795;
        5'd1: v = 24'd7778716;
        5'd2: v = 24'd4110060;
        5'd3: v = 24'd2086331;
        5'd4: v = 24'd1047214;
        5'd5: v = 24'd524117;
        5'd6: v = 24'd262123;
        5'd7: v = 24'd131069;
        5'd8: v = 24'd65536;
        5'd9: v = 24'd32768;
        5'd10: v = 24'd16384;
        5'd11: v = 24'd8192;
        5'd12: v = 24'd4096;
        5'd13: v = 24'd2048;
        5'd14: v = 24'd1024;
        5'd15: v = 24'd512;
        5'd16: v = 24'd256;
        5'd17: v = 24'd128;
        5'd18: v = 24'd64;
        5'd19: v = 24'd32;
        5'd20: v = 24'd16;
        5'd21: v = 24'd8;
        5'd22: v = 24'd4;
        5'd23: v = 24'd2;
        5'd24: v = 24'd1;
        default: v = 24'd0;
      endcase
      return v;
    end
  endfunction

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    begin
      if (x > 64'sd2147483647) r = 32'sh7fffffff;
      else if (x < -64'sd2147483648) r = 32'sh80000000;
      else r = x[31:0];
      return r;
    end
  endfunction

endpackage

[rtl/cae_tilt.sv]
// tilt angle unit: bit-serial square root then vectoring cordic, one step a cycle
module cae_tilt #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [16:0]  num,
  input  logic signed [15:0]  b,
  input  logic signed [15:0]  c,
  output logic                done,
  output logic signed [31:0]  angle
);
  import cae_pkg::*;

  localparam int ITERS = (CORDIC_STEPS > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STEPS;

  typedef enum logic [1:0] {T_IDLE, T_SQRT, T_CORDIC} tilt_state_t;

  tilt_state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  // root datapath: radicand (33 bits) << 32 gives 65 bits -> root 33 bits
  logic [65:0] rem_r, rem_nxt;
  logic [32:0] root_r, root_nxt;
  logic [65:0] rad_r, rad_nxt;
  logic signed [35:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [31:0] z_r, z_nxt;
  logic signed [16:0] num_r, num_nxt;
  logic done_r, done_nxt;

  logic [31:0] bsq, csq;
  logic [65:0] trial;
  logic [65:0] rem_sh;
  logic signed [35:0] dx, dy;
  logic [23:0] atv;

  assign bsq = 32'($signed(b) * $signed(b));
  assign csq = 32'($signed(c) * $signed(c));
  assign rem_sh = {rem_r[63:0], rad_r[65:64]};
  assign trial = {root_r[31:0], 2'b01};
  assign dx = y_r >>> cnt_r[4:0];
  assign dy = x_r >>> cnt_r[4:0];
  assign atv = atan_q24(cnt_r[4:0]);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE: if (start) state_nxt = T_SQRT;
      T_SQRT: if (cnt_r == 6'd32) state_nxt = T_CORDIC;
      T_CORDIC: if (cnt_r == 6'(ITERS - 1) || (x_r == 0 && y_r == 0)) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    root_nxt = root_r;
    rad_nxt = rad_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    num_nxt = num_r;
    done_nxt = 1'b0;
    unique case (state_r)
      T_IDLE: begin
        if (start) begin
          rad_nxt = {1'b0, 33'({1'b0, bsq} + {1'b0, csq}), 32'd0};
          rem_nxt = '0;
          root_nxt = '0;
          cnt_nxt = '0;
          num_nxt = num;
          z_nxt = '0;
        end
      end
      T_SQRT: begin
        // two radicand bits per step, 33 steps
        rad_nxt = {rad_r[63:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt = rem_sh - trial;
          root_nxt = {root_r[31:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          root_nxt = {root_r[31:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd32) begin
          x_nxt = 36'($signed({1'b0, root_nxt}));
          y_nxt = 36'($signed(num_r)) <<< 16;
          cnt_nxt = '0;
        end
      end
      T_CORDIC: begin
        if (x_r == 0 && y_r == 0) begin
          done_nxt = 1'b1;
        end else begin
          if (y_r >= 0) begin
            x_nxt = x_r + dx;
            y_nxt = y_r - dy;
            z_nxt = z_r + $signed({8'd0, atv});
          end else begin
            x_nxt = x_r - dx;
            y_nxt = y_r + dy;
            z_nxt = z_r - $signed({8'd0, atv});
          end
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r == 6'(ITERS - 1)) done_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    root_r <= root_nxt;
    rad_r <= rad_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    num_r <= num_nxt;
  end

  assign done = done_r;
  assign angle = z_r;
endmodule

[rtl/cae_div.sv]
// restoring divider for climb rate: |dividend| * 2^24 / dt, one quotient bit a cycle
module cae_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [33:0] diff,
  input  logic [24:0]        divisor,
  output logic               done,
  output logic signed [31:0] quot
);
  import cae_pkg::*;

  // dividend magnitude up to 2^33 * 2^24 = 58 bits
  localparam int DW = 58;

  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [25:0] rem_r, rem_nxt;
  logic [24:0] dsr_r, dsr_nxt;
  logic neg_r, neg_nxt;

  logic [25:0] rem_sh;
  logic [33:0] mag;
  logic signed [63:0] qs;

  assign mag = diff[33] ? 34'(-diff) : 34'(diff);
  assign rem_sh = {rem_r[24:0], dvd_r[DW-1]};
  assign qs = neg_r ? -$signed({6'd0, dvd_r}) : $signed({6'd0, dvd_r});

  // one quotient bit per step
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    neg_nxt = neg_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        cnt_nxt = '0;
        dvd_nxt = {mag, 24'd0};
        rem_nxt = '0;
        dsr_nxt = divisor;
        neg_nxt = diff[33];
      end
    end else begin
      if (rem_sh >= {1'b0, dsr_r}) begin
        rem_nxt = rem_sh - {1'b0, dsr_r};
        dvd_nxt = {dvd_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        dvd_nxt = {dvd_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quot = sat32(qs);
endmodule

[rtl/complementary_attitude_estimator.sv]
// top level of the complementary attitude estimator
// Usage: one IMU sample beat enters on the in_ channel (valid/ready) and one
// estimate beat leaves on the out_ channel (valid/ready) for every sample.
// The block takes one sample at a time: in_ready is low from acceptance until
// the result beat has been taken. Processing runs through one shared tilt
// unit (a bit-serial root plus CORDIC_STEPS cordic iterations, at most 32),
// used once for roll and once for pitch, then a blend and, with a barometer
// sample and nonzero dt, a restoring divider for the climb rate. The tilt
// unit ends early when a tilt vector is all zero. After the result beat is
// taken the sequencer returns to idle, where the next sample is accepted.
// A stalled receiver holds the result beat in the output register; no new
// sample is accepted until it is taken.
// Synchronous active-low reset clears all estimates and rates to zero and
// loads the default weights (0.98 attitude, 0.1 altitude).
// Weights are written through cfg_ at index 0 (attitude) and 1 (altitude); the
// user must write them only while idle, the block does not enforce this; values above 65536 act as 65536.
module complementary_attitude_estimator #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [cae_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cae_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [15:0]           in_accel_x,
  input  logic signed [15:0]           in_accel_y,
  input  logic signed [15:0]           in_accel_z,
  input  logic signed [23:0]           in_gyro_x,
  input  logic signed [23:0]           in_gyro_y,
  input  logic signed [23:0]           in_gyro_z,
  input  logic [24:0]                  in_step_time,
  input  logic                         in_baro_valid,
  input  logic signed [31:0]           in_baro_altitude,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [31:0]           out_roll_angle,
  output logic signed [31:0]           out_pitch_angle,
  output logic signed [31:0]           out_yaw_angle,
  output logic signed [23:0]           out_rate_roll,
  output logic signed [23:0]           out_rate_pitch,
  output logic signed [23:0]           out_rate_yaw,
  output logic signed [31:0]           out_altitude_est,
  output logic signed [31:0]           out_climb_rate
);
  import cae_pkg::*;

  cae_state_t state_r, state_nxt;
  logic [16:0] att_w_r, alt_w_r;
  logic signed [31:0] roll_r, pitch_r, yaw_r, alt_r, climb_r;
  logic signed [23:0] rate_x_r, rate_y_r, rate_z_r;
  logic signed [15:0] ax_r, ay_r, az_r;
  logic [24:0] dt_r;
  logic baro_v_r;
  logic signed [31:0] baro_r;
  logic signed [33:0] groll_r, gpitch_r;
  logic signed [31:0] aroll_r;
  logic out_valid_r;

  logic tilt_start, tilt_done, div_start, div_done;
  logic signed [16:0] t_num;
  logic signed [15:0] t_b, t_c;
  logic signed [31:0] t_angle, div_q;
  logic signed [33:0] alt_diff;

  logic [16:0] wa, wb;
  logic signed [49:0] inc_x, inc_y, inc_z;
  logic signed [33:0] rinc_x, rinc_y, rinc_z;
  logic signed [63:0] blend_r_v, blend_p_v, blend_a_v;
  logic signed [31:0] alt_new;

  assign wa = (att_w_r > WEIGHT_ONE) ? WEIGHT_ONE : att_w_r;
  assign wb = (alt_w_r > WEIGHT_ONE) ? WEIGHT_ONE : alt_w_r;

  // gyro increments, rounded Q40 -> Q24
  assign inc_x = rate_x_r * $signed({1'b0, dt_r});
  assign inc_y = rate_y_r * $signed({1'b0, dt_r});
  assign inc_z = rate_z_r * $signed({1'b0, dt_r});
  assign rinc_x = 34'((inc_x + 50'sd32768) >>> 16);
  assign rinc_y = 34'((inc_y + 50'sd32768) >>> 16);
  assign rinc_z = 34'((inc_z + 50'sd32768) >>> 16);

  // blends: (w*p + (1-w)*q + half) >> 16
  assign blend_r_v = ($signed({1'b0, wa}) * 64'(groll_r)
                     + $signed({1'b0, 17'(WEIGHT_ONE - wa)}) * 64'(aroll_r)
                     + 64'sd32768) >>> 16;
  assign blend_p_v = ($signed({1'b0, wa}) * 64'(gpitch_r)
                     + $signed({1'b0, 17'(WEIGHT_ONE - wa)}) * 64'(t_angle)
                     + 64'sd32768) >>> 16;
  assign blend_a_v = ($signed({1'b0, wb}) * 64'(baro_r)
                     + $signed({1'b0, 17'(WEIGHT_ONE - wb)}) * 64'(alt_r)
                     + 64'sd32768) >>> 16;
  assign alt_new = sat32(blend_a_v);
  // altitude change seen by the divider as it starts
  assign alt_diff = 34'(alt_new) - 34'(alt_r);

  // tilt operands: roll uses accel_y over (x,z), pitch uses -accel_x over (y,z)
  always_comb begin
    if (state_r == ST_GYRO) begin
      t_num = 17'(ay_r);
      t_b = ax_r;
    end else begin
      t_num = -17'(ax_r);
      t_b = ay_r;
    end
    t_c = az_r;
  end

  cae_tilt #(.CORDIC_STEPS(CORDIC_STEPS)) u_tilt (
    .clk(clk), .rst_n(rst_n), .start(tilt_start),
    .num(t_num), .b(t_b), .c(t_c), .done(tilt_done), .angle(t_angle)
  );

  cae_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .diff(alt_diff), .divisor(dt_r), .done(div_done), .quot(div_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid && in_ready) state_nxt = ST_GYRO;
      ST_GYRO: state_nxt = ST_CORDIC_R;
      ST_SQRT_R: state_nxt = ST_CORDIC_R;
      ST_CORDIC_R: if (tilt_done) state_nxt = ST_SQRT_P;
      ST_SQRT_P: state_nxt = ST_CORDIC_P;
      ST_CORDIC_P: if (tilt_done) state_nxt = ST_BLEND;
      ST_BLEND: state_nxt = baro_v_r ? ST_ALT : ST_DONE;
      ST_ALT: state_nxt = (dt_r != '0) ? ST_DIV : ST_DONE;
      ST_DIV: if (div_done) state_nxt = ST_DONE;
      ST_DONE: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    tilt_start = (state_r == ST_GYRO) || (state_r == ST_SQRT_P);
    div_start = (state_r == ST_ALT) && (dt_r != '0);
    in_ready = (state_r == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      att_w_r <= ATT_WEIGHT_RST;
      alt_w_r <= ALT_WEIGHT_RST;
      roll_r <= '0;
      pitch_r <= '0;
      yaw_r <= '0;
      rate_x_r <= '0;
      rate_y_r <= '0;
      rate_z_r <= '0;
      alt_r <= '0;
      climb_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ATT_WEIGHT: att_w_r <= cfg_data;
          REG_ALT_WEIGHT: alt_w_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_IDLE && in_valid) begin
        rate_x_r <= in_gyro_x;
        rate_y_r <= in_gyro_y;
        rate_z_r <= in_gyro_z;
      end
      if (state_r == ST_GYRO) yaw_r <= sat32(64'(yaw_r) + 64'(rinc_z));
      if (state_r == ST_BLEND) begin
        roll_r <= sat32(blend_r_v);
        pitch_r <= sat32(blend_p_v);
      end
      if (state_r == ST_ALT) alt_r <= alt_new;
      if (state_r == ST_DIV && div_done) climb_r <= div_q;
      // result beat
      if (state_nxt == ST_DONE && state_r != ST_DONE) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
  end

  // sample and working registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      ax_r <= in_accel_x;
      ay_r <= in_accel_y;
      az_r <= in_accel_z;
      dt_r <= in_step_time;
      baro_v_r <= in_baro_valid;
      baro_r <= in_baro_altitude;
    end
    if (state_r == ST_GYRO) begin
      groll_r <= 34'(roll_r) + rinc_x;
      gpitch_r <= 34'(pitch_r) + rinc_y;
    end
    if (state_r == ST_CORDIC_R && tilt_done) aroll_r <= t_angle;
  end

  assign out_valid = out_valid_r;
  assign out_roll_angle = roll_r;
  assign out_pitch_angle = pitch_r;
  assign out_yaw_angle = yaw_r;
  assign out_rate_roll = rate_x_r;
  assign out_rate_pitch = rate_y_r;
  assign out_rate_yaw = rate_z_r;
  assign out_altitude_est = alt_r;
  assign out_climb_rate = climb_r;
endmodule

[tb/sv/cae_checker.sv]
// checker for the attitude estimator: predicts each estimate beat and compares
`timescale 1ns / 100ps

module cae_checker #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cae_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cae_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [15:0]                in_accel_x,
  input  logic signed [15:0]                in_accel_y,
  input  logic signed [15:0]                in_accel_z,
  input  logic signed [23:0]                in_gyro_x,
  input  logic signed [23:0]                in_gyro_y,
  input  logic signed [23:0]                in_gyro_z,
  input  logic [24:0]                       in_step_time,
  input  logic                              in_baro_valid,
  input  logic signed [31:0]                in_baro_altitude,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [31:0]                out_roll_angle,
  input  logic signed [31:0]                out_pitch_angle,
  input  logic signed [31:0]                out_yaw_angle,
  input  logic signed [23:0]                out_rate_roll,
  input  logic signed [23:0]                out_rate_pitch,
  input  logic signed [23:0]                out_rate_yaw,
  input  logic signed [31:0]                out_altitude_est,
  input  logic signed [31:0]                out_climb_rate,
  output int                                fail_count,
  output int                                pending
);
  import cae_pkg::*;

  typedef struct {
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
    logic signed [23:0] rate_roll;
    logic signed [23:0] rate_pitch;
    logic signed [23:0] rate_yaw;
    logic signed [31:0] alt;
    logic signed [31:0] climb;
  } estimate_t;

  estimate_t expected_estimates[$];

  // predictor copy of the block state
  logic [16:0] att_w, alt_w;
  longint roll_q, pitch_q, yaw_q, alt_q, climb_q;

  localparam longint ATAN_TBL[32] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

  // floor shift of signed value
  function automatic longint floor_shr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint round_shr(longint x, int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint weight_of(logic [16:0] w);
    return (w > 17'd65536) ? 65536 : longint'(w);
  endfunction

  function automatic longint mix(longint w, longint p, longint q);
    return round_shr(w * p + (65536 - w) * q, 16);
  endfunction

  // bitwise integer root of an unsigned 64-bit value
  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // accelerometer tilt by vectoring cordic, radians Q24
  function automatic longint accel_tilt(longint num, longint b, longint c);
    longint unsigned s;
    longint x, y, z, dx, dy;
    int n;
    s = longint'(b * b) + longint'(c * c);
    x = longint'(int_root(s << 32));
    y = num * 65536;
    z = 0;
    n = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    if (x == 0 && y == 0) return 0;
    for (int i = 0; i < n; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + ATAN_TBL[i];
      end else begin
        x = x - dx; y = y + dy; z = z - ATAN_TBL[i];
      end
    end
    return z;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  estimate_t e, g;
  longint ax, ay, az, dt, wa, wb, g_roll, g_pitch, prev;

  always @(posedge clk) begin
    if (!rst_n) begin
      att_w = ATT_WEIGHT_RST;
      alt_w = ALT_WEIGHT_RST;
      roll_q = 0; pitch_q = 0; yaw_q = 0; alt_q = 0; climb_q = 0;
      expected_estimates.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ATT_WEIGHT) att_w = cfg_data;
        else if (cfg_index == REG_ALT_WEIGHT) alt_w = cfg_data;
      end
      // sample beat: advance predicted state
      if (in_valid && in_ready) begin
        ax = in_accel_x; ay = in_accel_y; az = in_accel_z;
        dt = longint'(in_step_time);
        wa = weight_of(att_w);
        g_roll = roll_q + round_shr(longint'(in_gyro_x) * dt, 16);
        g_pitch = pitch_q + round_shr(longint'(in_gyro_y) * dt, 16);
        yaw_q = clip32(yaw_q + round_shr(longint'(in_gyro_z) * dt, 16));
        roll_q = clip32(mix(wa, g_roll, accel_tilt(ay, ax, az)));
        pitch_q = clip32(mix(wa, g_pitch, accel_tilt(-ax, ay, az)));
        if (in_baro_valid) begin
          wb = weight_of(alt_w);
          prev = alt_q;
          alt_q = clip32(mix(wb, longint'(in_baro_altitude), prev));
          if (dt != 0) climb_q = clip32(((alt_q - prev) * 16777216) / dt);
        end
        e.roll = roll_q; e.pitch = pitch_q; e.yaw = yaw_q;
        e.rate_roll = in_gyro_x; e.rate_pitch = in_gyro_y; e.rate_yaw = in_gyro_z;
        e.alt = alt_q; e.climb = climb_q;
        expected_estimates.push_back(e);
      end
      // estimate beat: compare with oldest prediction
      if (out_valid && out_ready) begin
        if (expected_estimates.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          g = expected_estimates.pop_front();
          if (out_roll_angle !== g.roll) report_mismatch("roll", out_roll_angle, g.roll);
          if (out_pitch_angle !== g.pitch)
            report_mismatch("pitch", out_pitch_angle, g.pitch);
          if (out_yaw_angle !== g.yaw) report_mismatch("yaw", out_yaw_angle, g.yaw);
          if (out_rate_roll !== g.rate_roll)
            report_mismatch("roll rate", out_rate_roll, g.rate_roll);
          if (out_rate_pitch !== g.rate_pitch)
            report_mismatch("pitch rate", out_rate_pitch, g.rate_pitch);
          if (out_rate_yaw !== g.rate_yaw)
            report_mismatch("yaw rate", out_rate_yaw, g.rate_yaw);
          if (out_altitude_est !== g.alt)
            report_mismatch("altitude", out_altitude_est, g.alt);
          if (out_climb_rate !== g.climb)
            report_mismatch("climb rate", out_climb_rate, g.climb);
        end
      end
    end
    pending = expected_estimates.size();
  end

endmodule

[tb/sv/tb.sv]
// testbench top: stimulus, configuration phases and verdict
`timescale 1ns / 100ps

module tb;
  import cae_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_accel_x = '0, in_accel_y = '0, in_accel_z = '0;
  logic signed [23:0] in_gyro_x = '0, in_gyro_y = '0, in_gyro_z = '0;
  logic [24:0] in_step_time = '0;
  logic in_baro_valid = 1'b0;
  logic signed [31:0] in_baro_altitude = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_roll_angle, out_pitch_angle, out_yaw_angle;
  logic signed [23:0] out_rate_roll, out_rate_pitch, out_rate_yaw;
  logic signed [31:0] out_altitude_est, out_climb_rate;
  int fail_count, pending;
  int cycle_count = 0;
  int gap_left = 0;

  localparam int CYCLE_LIMIT = 1000000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  complementary_attitude_estimator i_dut (.*);
  cae_checker i_checker (.*);

  // timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stalls in a pattern: stretches of free flow and random stalls
  always @(negedge clk) begin
    if (cycle_count[12]) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [16:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one sample beat, held until accepted; bursts separated by random gaps
  task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             logic [23:0] gx, logic [23:0] gy, logic [23:0] gz,
                             logic [24:0] dt, logic bv, logic [31:0] alt);
    if (gap_left == 0) begin
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 200)) @(negedge clk);
      gap_left = $urandom_range(1, 12);
    end
    gap_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_accel_x <= ax; in_accel_y <= ay; in_accel_z <= az;
    in_gyro_x <= gx; in_gyro_y <= gy; in_gyro_z <= gz;
    in_step_time <= dt; in_baro_valid <= bv; in_baro_altitude <= alt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_random();
    logic [24:0] dt;
    case ($urandom_range(0, 5))
      0: dt = 25'd0;
      1: dt = 25'd16777216;
      2: dt = 25'($urandom);
      default: dt = 25'($urandom_range(1, 1 << 18));
    endcase
    if ($urandom_range(0, 3) == 0)
      send_sample(16'($urandom), 16'($urandom), 16'($urandom),
                  24'($urandom), 24'($urandom), 24'($urandom),
                  dt, 1'($urandom_range(0, 1)), $urandom);
    else
      // realistic small rates and altitudes so estimates stay in range
      send_sample(16'($urandom), 16'($urandom), 16'($urandom),
                  24'($signed($urandom_range(0, 1 << 19)) - (1 << 18)),
                  24'($signed($urandom_range(0, 1 << 19)) - (1 << 18)),
                  24'($signed($urandom_range(0, 1 << 19)) - (1 << 18)),
                  dt, 1'($urandom_range(0, 1)),
                  32'($signed($urandom_range(0, 1 << 24)) - (1 << 23)));
  endtask

  // let outstanding beats drain before touching the weights
  task automatic drain();
    while (in_valid || pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: field extremes, zero vector, no baro, zero dt, long dt
    send_sample('0, '0, '0, '0, '0, '0, 25'd1000, 1'b1, 32'sd65536);
    send_sample(16'h7fff, 16'h8000, 16'h7fff, 24'h7fffff, 24'h800000, 24'h7fffff,
                25'd16777216, 1'b1, 32'h7fffffff);
    send_sample(16'h8000, 16'h7fff, 16'h8000, 24'h800000, 24'h7fffff, 24'h800000,
                25'h1ffffff, 1'b1, 32'h80000000);
    send_sample(16'h8000, 16'h8000, 16'h8000, 24'h800000, 24'h800000, 24'h800000,
                25'h1ffffff, 1'b1, 32'h80000000);
    send_sample('0, '0, 16'd16384, 24'd1000, -24'sd1000, 24'd5, 25'd0, 1'b1, 32'sd1000);
    send_sample('0, 16'd100, '0, 24'd70000, 24'd0, 24'd0, 25'd16777, 1'b0, 32'sd777);
    send_sample(-16'sd200, '0, 16'd300, '0, 24'd3, '0, 25'd1, 1'b1, -32'sd500000);
    send_sample(16'h5555, 16'haaaa, 16'h5555, 24'h555555, 24'haaaaaa, 24'h555555,
                25'h0aaaaaa, 1'b1, 32'h55555555);
    send_sample(16'haaaa, 16'h5555, 16'haaaa, 24'haaaaaa, 24'h555555, 24'haaaaaa,
                25'h1555555, 1'b1, 32'haaaaaaaa);
    drain();

    // weight extremes: one, above one, zero, then max field value; then random and default weights
    write_reg(REG_ATT_WEIGHT, WEIGHT_ONE);
    write_reg(REG_ALT_WEIGHT, 17'h1ffff);
    repeat (150) send_random();
    drain();
    write_reg(REG_ATT_WEIGHT, 17'd0);
    write_reg(REG_ALT_WEIGHT, 17'd0);
    repeat (150) send_random();
    drain();
    write_reg(REG_ATT_WEIGHT, 17'h1ffff);
    write_reg(REG_ALT_WEIGHT, WEIGHT_ONE);
    repeat (150) send_random();
    drain();
    write_reg(REG_ATT_WEIGHT, 17'($urandom));
    write_reg(REG_ALT_WEIGHT, 17'($urandom));
    repeat (150) send_random();
    drain();
    write_reg(REG_ATT_WEIGHT, ATT_WEIGHT_RST);
    write_reg(REG_ALT_WEIGHT, ALT_WEIGHT_RST);
    repeat (200) send_random();
    drain();

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
